// ----- rtl/bmpnf_pkg.sv -----
package bmpnf_pkg;

    localparam logic [7:0] FILL_VALUE = 8'd255;
    localparam int unsigned MAX_COL_W = 13;
    localparam int unsigned SLOT_W = 3;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;
    localparam logic [11:0] SIZE_MIN     = 12'd5;
    localparam logic [11:0] HEIGHT_MAX   = 12'd4095;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       flush;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       last_of_frame;
    } out_beat_t;

    // Control and payload of one step as it moves from the input stage to the window stage.
    typedef struct packed {
        logic                 in_frame;
        logic                 visit;
        logic                 emit;
        logic                 last;
        logic                 wb_en;
        logic [7:0]           pix;
        logic [SLOT_W-1:0]    slot;
        logic [SLOT_W-1:0]    er_slot;
        logic [MAX_COL_W-1:0] col;
    } step_t;

endpackage

// ----- rtl/bmpnf_line_mem.sv -----
module bmpnf_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int WORD_W = 64
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            // A write to the same column in this cycle is passed straight through.
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bmpnf_window.sv -----
module bmpnf_window #(
    parameter int ROWS_KEPT = 8,
    parameter int COL_W     = 11
) (
    input  logic                     aclk,
    input  logic                     step_valid,
    input  bmpnf_pkg::step_t         step,
    input  logic [ROWS_KEPT*8-1:0]   rd_data,
    output logic                     wr_en,
    output logic [COL_W-1:0]         wr_addr,
    output logic [ROWS_KEPT*8-1:0]   wr_data,
    output logic                     push,
    output bmpnf_pkg::out_beat_t     push_data
);

    localparam int WORD_W = ROWS_KEPT * 8;

    logic [WORD_W-1:0] win_reg [5];
    logic [COL_W-1:0]  wcol_reg [5];
    logic [WORD_W-1:0] col_in;
    logic [WORD_W-1:0] nw [5];
    logic [WORD_W-1:0] nf [5];
    logic [bmpnf_pkg::SLOT_W-1:0] sl [5];
    logic [7:0] center;
    logic ring;
    logic fill;

    function automatic logic [bmpnf_pkg::SLOT_W-1:0] slot_back(
        input logic [bmpnf_pkg::SLOT_W-1:0] s,
        input logic [bmpnf_pkg::SLOT_W-1:0] k
    );
        logic [bmpnf_pkg::SLOT_W:0] t;
        if (s >= k) begin
            t = {1'b0, s} - {1'b0, k};
        end else begin
            t = {1'b0, s} + (bmpnf_pkg::SLOT_W+1)'(ROWS_KEPT) - {1'b0, k};
        end
        return t[bmpnf_pkg::SLOT_W-1:0];
    endfunction

    always_comb begin
        col_in = rd_data;
        if (step.in_frame) begin
            col_in[{step.slot, 3'b000} +: 8] = step.pix;
        end
        for (int i = 0; i < 4; i++) begin
            nw[i] = win_reg[i+1];
        end
        nw[4] = col_in;
        for (int j = 0; j < 5; j++) begin
            sl[j] = slot_back(step.slot, bmpnf_pkg::SLOT_W'(4 - j));
        end
        center = nw[2][{sl[2], 3'b000} +: 8];
        ring = 1'b1;
        for (int i = 0; i < 5; i++) begin
            ring = ring && (nw[i][{sl[0], 3'b000} +: 8] != 8'd0)
                        && (nw[i][{sl[4], 3'b000} +: 8] != 8'd0);
        end
        for (int j = 1; j < 4; j++) begin
            ring = ring && (nw[0][{sl[j], 3'b000} +: 8] != 8'd0)
                        && (nw[4][{sl[j], 3'b000} +: 8] != 8'd0);
        end
        fill = step.visit && (center == 8'd0) && ring;
        for (int i = 0; i < 5; i++) begin
            nf[i] = nw[i];
        end
        if (fill) begin
            for (int i = 1; i < 4; i++) begin
                for (int j = 1; j < 4; j++) begin
                    nf[i][{sl[j], 3'b000} +: 8] = bmpnf_pkg::FILL_VALUE;
                end
            end
        end
    end

    // The oldest column leaves the window; no later window of this row pass touches it.
    assign wr_en   = step_valid && step.wb_en;
    assign wr_addr = wcol_reg[1];
    assign wr_data = win_reg[1];

    assign push = step_valid && step.emit;
    assign push_data.pixel_out     = nf[1][{step.er_slot, 3'b000} +: 8];
    assign push_data.last_of_frame = step.last;

    always_ff @(posedge aclk) begin
        if (step_valid) begin
            for (int i = 0; i < 5; i++) begin
                win_reg[i] <= nf[i];
            end
            for (int i = 0; i < 4; i++) begin
                wcol_reg[i] <= wcol_reg[i+1];
            end
            wcol_reg[4] <= step.col[COL_W-1:0];
        end
    end

endmodule

// ----- rtl/bmpnf_out_fifo.sv -----
module bmpnf_out_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bmpnf_pkg::out_beat_t push_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmpnf_pkg::out_beat_t m_data,
    output logic [1:0]           count,
    output logic                 pop
);

    bmpnf_pkg::out_beat_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/binary_mask_pepper_noise_fill.sv -----
// Latency: a pixel leaves as the result of the item that comes 3*width+3 positions after it,
// and that result goes through the step register and then the output FIFO before it is offered.
// Throughput: one item per cycle while the output FIFO has room, set by the single column read
// and write-back port of the line memory; a flush item inside the frame is taken and dropped.
// Reset (aresetn low, synchronous) clears the pipeline and positions and restores
// width 640 and height 480; the line memory is not cleared.
module binary_mask_pepper_noise_fill #(
    parameter int LINE_LEN  = 2048,
    parameter int ROWS_KEPT = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmpnf_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmpnf_pkg::out_beat_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data
);

    localparam int COL_W  = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int WORD_W = ROWS_KEPT * 8;

    logic [11:0] w_reg, w_next;
    logic [11:0] h_reg, h_next;
    logic [12:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [bmpnf_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [11:0] er_reg, er_next;
    logic [COL_W-1:0] ec_reg, ec_next;
    logic [bmpnf_pkg::SLOT_W-1:0] er_slot_reg, er_slot_next;
    logic [2:0] fill_reg, fill_next;
    logic s1_valid_reg, s1_valid_next;
    bmpnf_pkg::step_t step_reg, step_next;

    logic fire, in_frame, ignore, emit, last, col_end, ec_end;
    logic [11:0] cfg_clamped;
    logic [WORD_W-1:0] rd_data, wr_data;
    logic wr_en, push, pop;
    logic [COL_W-1:0] wr_addr;
    logic [1:0] fifo_count;
    bmpnf_pkg::out_beat_t push_data;

    assign cfg_ready = 1'b1;

    // Room is needed for the step in the window stage and for the one accepted now.
    assign s_ready = ({1'b0, fifo_count} + {2'b0, s1_valid_reg}) <= (3'd1 + {2'b0, pop});
    assign fire    = s_valid && s_ready;

    assign in_frame = row_reg < {1'b0, h_reg};
    assign ignore   = in_frame && s_data.flush;
    assign emit     = (row_reg > 13'd3) || ((row_reg == 13'd3) && (col_reg >= COL_W'(3)));
    assign col_end  = (14'(col_reg) + 14'd1) == 14'(w_reg);
    assign ec_end   = (14'(ec_reg) + 14'd1) == 14'(w_reg);
    assign last     = emit && ((13'(er_reg) + 13'd1) == {1'b0, h_reg}) && ec_end;

    always_comb begin
        cfg_clamped = cfg_data;
        if (cfg_data < bmpnf_pkg::SIZE_MIN) begin
            cfg_clamped = bmpnf_pkg::SIZE_MIN;
        end
    end

    always_comb begin
        w_next        = w_reg;
        h_next        = h_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        slot_next     = slot_reg;
        er_next       = er_reg;
        ec_next       = ec_reg;
        er_slot_next  = er_slot_reg;
        fill_next     = fill_reg;
        s1_valid_next = fire && !ignore;

        step_next          = step_reg;
        step_next.in_frame = in_frame;
        step_next.visit    = in_frame && (row_reg >= 13'd4) && (col_reg >= COL_W'(4));
        step_next.emit     = emit;
        step_next.last     = last;
        step_next.wb_en    = (fill_reg == 3'd4);
        step_next.pix      = s_data.pixel_in;
        step_next.slot     = slot_reg;
        step_next.er_slot  = er_slot_reg;
        step_next.col      = bmpnf_pkg::MAX_COL_W'(col_reg);

        if (fire && !ignore) begin
            if (last) begin
                row_next     = 13'd0;
                col_next     = '0;
                slot_next    = '0;
                er_next      = 12'd0;
                ec_next      = '0;
                er_slot_next = '0;
                fill_next    = 3'd0;
            end else begin
                if (emit) begin
                    if (ec_end) begin
                        ec_next = '0;
                        er_next = er_reg + 12'd1;
                        if (32'(er_slot_reg) == ROWS_KEPT - 1) begin
                            er_slot_next = '0;
                        end else begin
                            er_slot_next = er_slot_reg + 1'b1;
                        end
                    end else begin
                        ec_next = ec_reg + 1'b1;
                    end
                end
                if (col_end) begin
                    col_next = '0;
                    row_next = row_reg + 13'd1;
                    if (32'(slot_reg) == ROWS_KEPT - 1) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
                if (fill_reg != 3'd4) begin
                    fill_next = fill_reg + 3'd1;
                end
            end
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bmpnf_pkg::CFG_FRAME_WIDTH: begin
                    w_next = cfg_clamped;
                    if (32'(cfg_clamped) > LINE_LEN) begin
                        w_next = 12'(LINE_LEN);
                    end
                end
                bmpnf_pkg::CFG_FRAME_HEIGHT: begin
                    h_next = cfg_clamped;
                end
                default: begin
                end
            endcase
            if ((cfg_index == bmpnf_pkg::CFG_FRAME_WIDTH) ||
                (cfg_index == bmpnf_pkg::CFG_FRAME_HEIGHT)) begin
                row_next     = 13'd0;
                col_next     = '0;
                slot_next    = '0;
                er_next      = 12'd0;
                ec_next      = '0;
                er_slot_next = '0;
                fill_next    = 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg        <= bmpnf_pkg::WIDTH_RESET;
            h_reg        <= bmpnf_pkg::HEIGHT_RESET;
            row_reg      <= 13'd0;
            col_reg      <= '0;
            slot_reg     <= '0;
            er_reg       <= 12'd0;
            ec_reg       <= '0;
            er_slot_reg  <= '0;
            fill_reg     <= 3'd0;
            s1_valid_reg <= 1'b0;
        end else begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            slot_reg     <= slot_next;
            er_reg       <= er_next;
            ec_reg       <= ec_next;
            er_slot_reg  <= er_slot_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && !ignore) begin
            step_reg <= step_next;
        end
    end

    bmpnf_line_mem #(
        .DEPTH  (LINE_LEN),
        .ADDR_W (COL_W),
        .WORD_W (WORD_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (fire && !ignore),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bmpnf_window #(
        .ROWS_KEPT (ROWS_KEPT),
        .COL_W     (COL_W)
    ) u_window (
        .aclk       (aclk),
        .step_valid (s1_valid_reg),
        .step       (step_reg),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_data  (push_data)
    );

    bmpnf_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count),
        .pop       (pop)
    );

endmodule

// ----- rtl/bmpnf_checker.sv -----
module bmpnf_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input bmpnf_pkg::out_beat_t m_data
);

    // A stalled result beat stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // Input back-pressure only comes from results that wait downstream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result waiting");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

endmodule

bind binary_mask_pepper_noise_fill bmpnf_checker u_bmpnf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/binary_mask_pepper_noise_fill_test.sv -----
module binary_mask_pepper_noise_fill_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_MAX = 2048;
    localparam int unsigned LINES = 8;
    localparam logic [1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [1:0] CFG_UNUSED_B = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    bmpnf_pkg::in_beat_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    bmpnf_pkg::out_beat_t m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [11:0]          cfg_data = '0;

    binary_mask_pepper_noise_fill DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Mirror of the mask rows and the raster position.
    logic [7:0]  mask_rows [0:LINES*LINE_MAX-1];
    int unsigned width_reg = bmpnf_pkg::WIDTH_RESET;
    int unsigned height_reg = bmpnf_pkg::HEIGHT_RESET;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    int unsigned pixels_out = 0;

    bmpnf_pkg::in_beat_t  pixel_q[$];
    bmpnf_pkg::out_beat_t filtered_q[$];
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned frames_done = 0;
    int unsigned fills_seen = 0;
    bit          hold_go = 1'b0;
    bit          hold_on = 1'b0;
    int unsigned hold_count = 0;

    function automatic int unsigned clamp_w();
        if (width_reg < bmpnf_pkg::SIZE_MIN) return bmpnf_pkg::SIZE_MIN;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned clamp_h();
        if (height_reg < bmpnf_pkg::SIZE_MIN) return bmpnf_pkg::SIZE_MIN;
        if (height_reg > bmpnf_pkg::HEIGHT_MAX) return bmpnf_pkg::HEIGHT_MAX;
        return height_reg;
    endfunction

    function automatic int unsigned addr(int unsigned r, int unsigned c);
        if (c >= LINE_MAX) c = LINE_MAX - 1;
        return (r % LINES) * LINE_MAX + c;
    endfunction

    function automatic void fill_window(int unsigned yc, int unsigned xc);
        bit ring;
        ring = 1'b1;
        if (mask_rows[addr(yc, xc)] != 8'd0) return;
        for (int k = 0; k < 5; k++) begin
            ring = ring && mask_rows[addr(yc - 2, xc - 2 + k)] != 0
                        && mask_rows[addr(yc + 2, xc - 2 + k)] != 0;
        end
        for (int k = 0; k < 3; k++) begin
            ring = ring && mask_rows[addr(yc - 1 + k, xc - 2)] != 0
                        && mask_rows[addr(yc - 1 + k, xc + 2)] != 0;
        end
        if (!ring) return;
        fills_seen++;
        for (int k = 0; k < 9; k++)
            mask_rows[addr(yc - 1 + k / 3, xc - 1 + k % 3)] = bmpnf_pkg::FILL_VALUE;
    endfunction

    function automatic void restart_raster();
        row_pos = 0;
        col_pos = 0;
        pixels_out = 0;
    endfunction

    function automatic void predict_pixel(bmpnf_pkg::in_beat_t b);
        int unsigned w, total, pos;
        bmpnf_pkg::out_beat_t o;
        w = clamp_w();
        total = w * clamp_h();
        pos = row_pos * w + col_pos;
        if (pos < total) begin
            if (b.flush) return;
            mask_rows[addr(row_pos, col_pos)] = b.pixel_in;
            if (row_pos >= 4 && col_pos >= 4) fill_window(row_pos - 2, col_pos - 2);
        end
        if (pos >= 3 * w + 3) begin
            o.pixel_out = mask_rows[addr(pixels_out / w, pixels_out % w)];
            o.last_of_frame = (pixels_out + 1 == total);
            filtered_q.insert(filtered_q.size(), o);
            if (o.last_of_frame) begin
                restart_raster();
                return;
            end
            pixels_out++;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pixel(s_data);
                beats_in++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pixel_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the line pipeline backs up into the input.
    always @(posedge aclk) begin
        if (hold_go && hold_count < 400) begin
            hold_on <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        bmpnf_pkg::out_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: pixel %0d last %0b",
                                 m_data.pixel_out, m_data.last_of_frame);
                end else begin
                    want = filtered_q.pop_front();
                    if (want.last_of_frame) frames_done++;
                    if (m_data.pixel_out !== want.pixel_out
                            || m_data.last_of_frame !== want.last_of_frame) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: expected pixel %0d last %0b, got %0d %0b",
                                     beats_out, want.pixel_out, want.last_of_frame,
                                     m_data.pixel_out, m_data.last_of_frame);
                    end
                end
            end
            m_ready <= !hold_on && $urandom_range(99) >= snk_idle_pct;
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() > 0 || s_valid || filtered_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == bmpnf_pkg::CFG_FRAME_WIDTH) begin
            width_reg = val;
            restart_raster();
        end else if (idx == bmpnf_pkg::CFG_FRAME_HEIGHT) begin
            height_reg = val;
            restart_raster();
        end
    endtask

    task automatic push_pixel(logic [7:0] p, logic fl);
        bmpnf_pkg::in_beat_t b;
        b.pixel_in = p;
        b.flush = fl;
        pixel_q.insert(pixel_q.size(), b);
    endtask

    // Mostly white masks with sparse black holes, so fills actually trigger.
    task automatic send_frame(int unsigned hole_pct);
        int unsigned w, total;
        w = clamp_w();
        total = w * clamp_h();
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(99) < 3) push_pixel(8'($urandom), 1'b1);
            if ($urandom_range(99) < hole_pct) push_pixel(8'd0, 1'b0);
            else push_pixel(8'($urandom_range(255, 1)), 1'b0);
        end
        // Pixels past the frame end behave as drain beats.
        for (int unsigned i = 0; i < 3 * w + 3; i++) begin
            if ($urandom_range(99) < 20) push_pixel(8'($urandom), 1'b0);
            else push_pixel(8'($urandom), 1'b1);
        end
    endtask

    initial begin
        for (int i = 0; i < LINES * LINE_MAX; i++) mask_rows[i] = 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(bmpnf_pkg::CFG_FRAME_WIDTH, 12'd0);
        write_reg(bmpnf_pkg::CFG_FRAME_HEIGHT, 12'd5);
        write_reg(CFG_UNUSED_A, 12'hFFF);
        // One isolated black pixel inside a white ring, plus a flush inside the frame.
        for (int i = 0; i < 25; i++) begin
            if (i == 12) push_pixel(8'd0, 1'b0);
            else if (i == 6) push_pixel(8'd1, 1'b0);
            else if (i == 18) push_pixel(8'd128, 1'b0);
            else push_pixel(8'd255, 1'b0);
            if (i == 10) push_pixel(8'd77, 1'b1);
        end
        for (int i = 0; i < 18; i++) push_pixel(8'hFF, i % 3 == 0 ? 1'b0 : 1'b1);
        wait_idle();

        // A frame abandoned part way by a register write.
        for (int i = 0; i < 12; i++) push_pixel(8'd255, 1'b0);
        wait_idle();
        write_reg(CFG_UNUSED_B, 12'd7);
        write_reg(bmpnf_pkg::CFG_FRAME_HEIGHT, 12'd0);
        send_frame(20);
        wait_idle();

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = phase == 0 ? 10 : phase == 1 ? 47 : 0;
            snk_idle_pct = phase == 0 ? 47 : phase == 1 ? 10 : 0;
            if (phase == 1) hold_go = 1'b1;
            for (int f = 0; f < 2; f++) begin
                write_reg(bmpnf_pkg::CFG_FRAME_WIDTH, 12'($urandom_range(9, 4)));
                write_reg(bmpnf_pkg::CFG_FRAME_HEIGHT, 12'($urandom_range(7, 3)));
                send_frame($urandom_range(25, 5));
                send_frame($urandom_range(25, 5));
                wait_idle();
            end
        end

        // Widest lines cut short by the next write, then only the start of the tallest frame.
        write_reg(bmpnf_pkg::CFG_FRAME_WIDTH, 12'd4095);
        write_reg(bmpnf_pkg::CFG_FRAME_HEIGHT, 12'd5);
        for (int i = 0; i < 40; i++) push_pixel(8'($urandom_range(255, 1)), 1'b0);
        wait_idle();
        write_reg(bmpnf_pkg::CFG_FRAME_WIDTH, 12'd5);
        write_reg(bmpnf_pkg::CFG_FRAME_HEIGHT, 12'd4095);
        for (int i = 0; i < 60; i++)
            push_pixel(($urandom_range(99) < 10) ? 8'd0 : 8'd255, 1'b0);
        wait_idle();

        $display("Covered %0d input beats and %0d output beats over %0d complete frames,",
                 beats_in, beats_out, frames_done);
        $display("with %0d window fills, clamped sizes, in-frame flushes and cut-short frames.",
                 fills_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("Timed out");
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/bmpnf_pkg.sv
rtl/bmpnf_line_mem.sv
rtl/bmpnf_window.sv
rtl/bmpnf_out_fifo.sv
rtl/binary_mask_pepper_noise_fill.sv
rtl/bmpnf_checker.sv
tb/binary_mask_pepper_noise_fill_test.sv
